// ===== rtl/srtq_pkg.sv =====
`default_nettype none
package srtq_pkg;

  localparam int TIMER_SLOTS_DEF   = 16;
  localparam int ONESHOT_SLOTS_DEF = 16;

  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_ONESHOT = 2'd1;
  localparam logic [1:0] ACT_REMOVE  = 2'd2;
  localparam logic [1:0] ACT_RUN     = 2'd3;

  localparam logic [2:0] KIND_TIMER   = 3'd0;
  localparam logic [2:0] KIND_ONESHOT = 3'd1;
  localparam logic [2:0] KIND_ADD     = 3'd2;
  localparam logic [2:0] KIND_REMOVE  = 3'd3;
  localparam logic [2:0] KIND_RUN     = 3'd4;

  localparam logic [1:0] ADDR_PRECISION = 2'd0;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] now_time;
    logic [47:0] start_time;
    logic [15:0] repeat_count;
    logic [31:0] interval;
    logic [15:0] tag;
    logic [31:0] timer_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] tag_res;
    logic [31:0] timer_id_res;
    logic [15:0] remaining;
    logic [5:0]  fired_count;
    logic        accepted;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [47:0] deadline;
    logic [31:0] interval;
    logic [15:0] remaining;
    logic [15:0] tag;
    logic [31:0] ident;
  } slot_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD, S_OSADD, S_RM_RD, S_RM_CMP, S_RUN, S_OS_RD, S_OS_EM,
    S_TM_RD, S_TM_CMP, S_MG_RD, S_MG_CAP, S_SC_RD, S_SC_CMP, S_MG_INS, S_DONE
  } state_t;

  function automatic logic [47:0] sat48(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sorted_repeating_timer_queue_top.sv =====
// Channel   Ports                              Transfer
// input     start, busy, in_data               start && !busy
// result    out_valid, out_data                out_valid, one cycle, no back-pressure
// config    psel, penable, pwrite, paddr, ...  psel && penable && pwrite
//
// Add and one-shot add finish in S_ADD or S_OSADD; remove scans the slot memory with
// a read and a compare per slot. A run emits each one-shot, reads each timer in the
// order and compares it unless removed or stopped, then drops each waiting timer or
// compares it per entry and inserts it (read port bound); skipped runs end in S_RUN.
// rst_n is synchronous; olen, wlen, flags, fill and bank clear; id counter loads 1.
// busy is high while a transaction is in progress; results cannot be stalled.
`default_nettype none
module sorted_repeating_timer_queue_top
  import srtq_pkg::*;
#(
  parameter int TIMER_SLOTS   = TIMER_SLOTS_DEF,
  parameter int ONESHOT_SLOTS = ONESHOT_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_t         in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SW   = $clog2(TIMER_SLOTS);
  localparam int LW   = $clog2(TIMER_SLOTS + 1);
  localparam int FW   = $clog2(ONESHOT_SLOTS + 1);
  localparam int OA   = $clog2(2 * ONESHOT_SLOTS);
  localparam int MAXN = (TIMER_SLOTS > ONESHOT_SLOTS) ? TIMER_SLOTS : ONESHOT_SLOTS;
  localparam int IW   = $clog2(MAXN + 1);

  state_t state_r, state_nxt;
  in_t    req_r, req_nxt;
  logic [31:0] tick_r;
  logic [47:0] nrt_r, nrt_nxt;
  logic [31:0] id_ctr_r, id_ctr_nxt;
  logic        bank_r, bank_nxt;
  logic [FW-1:0] fill_r [2];
  logic [FW-1:0] fill_nxt [2];
  logic [TIMER_SLOTS-1:0] valid_r, valid_nxt, rmv_r, rmv_nxt;
  logic [SW-1:0] order_r [TIMER_SLOTS];
  logic [SW-1:0] order_nxt [TIMER_SLOTS];
  logic [SW-1:0] wait_r [TIMER_SLOTS];
  logic [SW-1:0] wait_nxt [TIMER_SLOTS];
  logic [LW-1:0] olen_r, olen_nxt, wlen_r, wlen_nxt, klen_r, klen_nxt;
  logic [LW-1:0] j_r, j_nxt, pos_r, pos_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic          stop_r, stop_nxt;
  logic [5:0]    fired_r, fired_nxt;
  logic [SW-1:0] sidx_r, sidx_nxt;
  logic [47:0]   dl_r, dl_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  // slot memory
  slot_t         slot_mem [TIMER_SLOTS];
  slot_t         srd_r, s_wd;
  logic          s_we;
  logic [SW-1:0] s_wa, s_ra;
  // one-shot tag memory, two banks
  logic [15:0]   os_mem [2*ONESHOT_SLOTS];
  logic [15:0]   osrd_r, os_wd;
  logic          os_we;
  logic [OA-1:0] os_wa, os_ra;

  always_ff @(posedge clk) begin
    if (s_we) slot_mem[s_wa] <= s_wd;
    srd_r <= slot_mem[s_ra];
    if (os_we) os_mem[os_wa] <= os_wd;
    osrd_r <= os_mem[os_ra];
  end

  function automatic logic [OA-1:0] os_addr(logic b, logic [IW-1:0] idx);
    return b ? OA'(ONESHOT_SLOTS) + OA'(idx) : OA'(idx);
  endfunction

  // status terms shared by the control blocks
  logic          free_found;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = TIMER_SLOTS - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        free_found = 1'b1;
        free_idx   = SW'(k);
      end
    end
  end

  logic          add_full, skip, os_more, tm_more, mg_more, sc_more;
  logic          rm_hit, rm_end, due, sc_less, olen_full;
  logic [SW-1:0] tm_s, mg_s, rm_s;
  logic [15:0]   rem_dec;
  logic          wr_cfg;

  assign add_full  = !free_found || (wlen_r == LW'(TIMER_SLOTS));
  assign skip      = req_r.now_time < nrt_r;
  assign os_more   = i_r < IW'(fill_r[bank_r]);
  assign tm_more   = i_r < IW'(olen_r);
  assign mg_more   = i_r < IW'(wlen_r);
  assign sc_more   = j_r < olen_r;
  assign tm_s      = order_r[i_r[SW-1:0]];
  assign mg_s      = wait_r[i_r[SW-1:0]];
  assign rm_s      = i_r[SW-1:0];
  assign rm_hit    = valid_r[rm_s] && (srd_r.ident == req_r.timer_id);
  assign rm_end    = i_r == IW'(TIMER_SLOTS - 1);
  assign due       = req_r.now_time >= srd_r.deadline;
  assign sc_less   = dl_r < srd_r.deadline;
  assign olen_full = olen_r >= LW'(TIMER_SLOTS);
  assign rem_dec   = srd_r.remaining - 16'd1;
  assign wr_cfg    = psel && penable && pwrite;

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign prdata    = tick_r;
  assign pready    = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.action)
            ACT_ADD:     state_nxt = S_ADD;
            ACT_ONESHOT: state_nxt = S_OSADD;
            ACT_REMOVE:  state_nxt = S_RM_RD;
            default:     state_nxt = S_RUN;
          endcase
        end
      end
      S_ADD, S_OSADD: state_nxt = S_IDLE;
      S_RM_RD:  state_nxt = S_RM_CMP;
      S_RM_CMP: state_nxt = (rm_hit || rm_end) ? S_IDLE : S_RM_RD;
      S_RUN:    state_nxt = skip ? S_IDLE : S_OS_RD;
      S_OS_RD:  state_nxt = os_more ? S_OS_EM : S_TM_RD;
      S_OS_EM:  state_nxt = S_OS_RD;
      S_TM_RD: begin
        if (!tm_more) state_nxt = S_MG_RD;
        else if (rmv_r[tm_s] || stop_r) state_nxt = S_TM_RD;
        else state_nxt = S_TM_CMP;
      end
      S_TM_CMP: state_nxt = S_TM_RD;
      S_MG_RD: begin
        if (!mg_more) state_nxt = S_DONE;
        else if (rmv_r[mg_s] || olen_full) state_nxt = S_MG_RD;
        else state_nxt = S_MG_CAP;
      end
      S_MG_CAP: state_nxt = S_SC_RD;
      S_SC_RD:  state_nxt = sc_more ? S_SC_CMP : S_MG_INS;
      S_SC_CMP: state_nxt = sc_less ? S_MG_INS : S_SC_RD;
      S_MG_INS: state_nxt = S_MG_RD;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory controls and results
  always_comb begin
    req_nxt       = req_r;
    nrt_nxt       = nrt_r;
    id_ctr_nxt    = id_ctr_r;
    bank_nxt      = bank_r;
    fill_nxt      = fill_r;
    valid_nxt     = valid_r;
    rmv_nxt       = rmv_r;
    order_nxt     = order_r;
    wait_nxt      = wait_r;
    olen_nxt      = olen_r;
    wlen_nxt      = wlen_r;
    klen_nxt      = klen_r;
    j_nxt         = j_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    stop_nxt      = stop_r;
    fired_nxt     = fired_r;
    sidx_nxt      = sidx_r;
    dl_nxt        = dl_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    s_we          = 1'b0;
    s_wa          = sidx_r;
    s_wd          = srd_r;
    s_ra          = sidx_r;
    os_we         = 1'b0;
    os_wa         = '0;
    os_wd         = req_r.tag;
    os_ra         = os_addr(bank_r, i_r);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_data;
          i_nxt   = '0;
        end
      end
      S_ADD: begin
        out_valid_nxt = 1'b1;
        out_nxt.kind  = KIND_ADD;
        out_nxt.last  = 1'b1;
        if (!add_full) begin
          out_nxt.timer_id_res = (id_ctr_r == 32'd0) ? 32'd1 : id_ctr_r;
          out_nxt.accepted     = 1'b1;
          id_ctr_nxt           = out_nxt.timer_id_res + 32'd1;
          s_we                 = 1'b1;
          s_wa                 = free_idx;
          s_wd.deadline        = req_r.start_time;
          s_wd.interval        = req_r.interval;
          s_wd.remaining       = (req_r.repeat_count == 16'd0) ? 16'd1 : req_r.repeat_count;
          s_wd.tag             = req_r.tag;
          s_wd.ident           = out_nxt.timer_id_res;
          valid_nxt[free_idx]  = 1'b1;
          rmv_nxt[free_idx]    = 1'b0;
          wait_nxt[wlen_r[SW-1:0]] = free_idx;
          wlen_nxt             = wlen_r + LW'(1);
        end
      end
      S_OSADD: begin
        out_valid_nxt = 1'b1;
        out_nxt.kind  = KIND_ADD;
        out_nxt.last  = 1'b1;
        if (fill_r[!bank_r] < FW'(ONESHOT_SLOTS)) begin
          os_we             = 1'b1;
          os_wa             = os_addr(!bank_r, IW'(fill_r[!bank_r]));
          fill_nxt[!bank_r] = fill_r[!bank_r] + FW'(1);
          out_nxt.accepted  = 1'b1;
        end
      end
      S_RM_RD: s_ra = rm_s;
      S_RM_CMP: begin
        if (rm_hit || rm_end) begin
          out_valid_nxt    = 1'b1;
          out_nxt.kind     = KIND_REMOVE;
          out_nxt.accepted = rm_hit;
          out_nxt.last     = 1'b1;
          if (rm_hit) rmv_nxt[rm_s] = 1'b1;
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end
      S_RUN: begin
        fired_nxt = '0;
        if (skip) begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = KIND_RUN;
          out_nxt.last  = 1'b1;
        end else begin
          nrt_nxt = sat48(req_r.now_time, tick_r);
        end
      end
      S_OS_RD: begin
        if (!os_more) begin
          fill_nxt[bank_r] = '0;
          i_nxt            = '0;
          klen_nxt         = '0;
          stop_nxt         = 1'b0;
        end
      end
      S_OS_EM: begin
        out_valid_nxt   = 1'b1;
        out_nxt.kind    = KIND_ONESHOT;
        out_nxt.tag_res = osrd_r;
        fired_nxt       = fired_r + 6'd1;
        i_nxt           = i_r + IW'(1);
      end
      S_TM_RD: begin
        s_ra = tm_s;
        if (!tm_more) begin
          olen_nxt = klen_r;
          bank_nxt = !bank_r;
          i_nxt    = '0;
        end else if (rmv_r[tm_s]) begin
          valid_nxt[tm_s] = 1'b0;
          rmv_nxt[tm_s]   = 1'b0;
          i_nxt           = i_r + IW'(1);
        end else if (stop_r) begin
          // keep list is compacted in place; klen never passes i
          order_nxt[klen_r[SW-1:0]] = tm_s;
          klen_nxt = klen_r + LW'(1);
          i_nxt    = i_r + IW'(1);
        end else begin
          sidx_nxt = tm_s;
        end
      end
      S_TM_CMP: begin
        i_nxt = i_r + IW'(1);
        if (!due) begin
          stop_nxt = 1'b1;
          order_nxt[klen_r[SW-1:0]] = sidx_r;
          klen_nxt = klen_r + LW'(1);
        end else begin
          out_valid_nxt        = 1'b1;
          out_nxt.kind         = KIND_TIMER;
          out_nxt.tag_res      = srd_r.tag;
          out_nxt.timer_id_res = srd_r.ident;
          out_nxt.remaining    = rem_dec;
          fired_nxt            = fired_r + 6'd1;
          s_we                 = 1'b1;
          s_wd.deadline        = sat48(srd_r.deadline, srd_r.interval);
          s_wd.remaining       = rem_dec;
          if (rem_dec != 16'd0 && wlen_r < LW'(TIMER_SLOTS)) begin
            wait_nxt[wlen_r[SW-1:0]] = sidx_r;
            wlen_nxt = wlen_r + LW'(1);
          end else begin
            valid_nxt[sidx_r] = 1'b0;
            rmv_nxt[sidx_r]   = 1'b0;
          end
        end
      end
      S_MG_RD: begin
        s_ra = mg_s;
        if (!mg_more) begin
          wlen_nxt = '0;
        end else if (rmv_r[mg_s] || olen_full) begin
          valid_nxt[mg_s] = 1'b0;
          rmv_nxt[mg_s]   = 1'b0;
          i_nxt           = i_r + IW'(1);
        end else begin
          sidx_nxt = mg_s;
        end
      end
      S_MG_CAP: begin
        dl_nxt  = srd_r.deadline;
        j_nxt   = '0;
        pos_nxt = olen_r;
      end
      S_SC_RD: s_ra = order_r[j_r[SW-1:0]];
      S_SC_CMP: begin
        // first entry with a later deadline; equal deadlines stay ahead
        if (sc_less) pos_nxt = j_r;
        else j_nxt = j_r + LW'(1);
      end
      S_MG_INS: begin
        for (int k = 1; k < TIMER_SLOTS; k++) begin
          if (LW'(k) > pos_r && LW'(k) <= olen_r) order_nxt[k] = order_r[k-1];
        end
        order_nxt[pos_r[SW-1:0]] = sidx_r;
        olen_nxt = olen_r + LW'(1);
        i_nxt    = i_r + IW'(1);
      end
      S_DONE: begin
        out_valid_nxt       = 1'b1;
        out_nxt.kind        = KIND_RUN;
        out_nxt.fired_count = fired_r;
        out_nxt.last        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      nrt_r       <= '0;
      id_ctr_r    <= 32'd1;
      bank_r      <= 1'b0;
      fill_r[0]   <= '0;
      fill_r[1]   <= '0;
      valid_r     <= '0;
      rmv_r       <= '0;
      olen_r      <= '0;
      wlen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (wr_cfg) tick_r <= pwdata;
      nrt_r       <= nrt_nxt;
      id_ctr_r    <= id_ctr_nxt;
      bank_r      <= bank_nxt;
      fill_r      <= fill_nxt;
      valid_r     <= valid_nxt;
      rmv_r       <= rmv_nxt;
      olen_r      <= olen_nxt;
      wlen_r      <= wlen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    order_r <= order_nxt;
    wait_r  <= wait_nxt;
    klen_r  <= klen_nxt;
    j_r     <= j_nxt;
    pos_r   <= pos_nxt;
    i_r     <= i_nxt;
    stop_r  <= stop_nxt;
    fired_r <= fired_nxt;
    sidx_r  <= sidx_nxt;
    dl_r    <= dl_nxt;
    out_r   <= out_nxt;
  end

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy)
    else $error("final result while still busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not start");
  a_olen: assert property (@(posedge clk) disable iff (!rst_n)
    olen_r <= LW'(TIMER_SLOTS) && wlen_r <= LW'(TIMER_SLOTS))
    else $error("order or wait length out of range");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= FW'(ONESHOT_SLOTS) && fill_r[1] <= FW'(ONESHOT_SLOTS))
    else $error("one-shot fill out of range");

endmodule
`default_nettype wire
